>>> src/stpax_pkg.sv
// Shared types and constants for the stepper axis step/dir homing unit.
package stpax_pkg;

   localparam int POS_BITS   = 16;
   localparam int CNT_BITS   = 16;
   localparam int MOVE_BITS  = 17;
   localparam int MODE_BITS  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [POS_BITS-1:0] MAX_POSITION_RESET  = 16'd2000;
   localparam logic [CNT_BITS-1:0] STEP_INTERVAL_RESET = 16'd0;

   // Item kinds carried on req_tuser.
   localparam logic [MODE_BITS-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MOVE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_HOME = 2'd2;

   // Register select, taken from paddr[2].
   localparam logic REG_MAX_POSITION  = 1'b0;
   localparam logic REG_STEP_INTERVAL = 1'b1;

   typedef struct packed {
      logic                rejected;
      logic                busy_res;
      logic [POS_BITS-1:0] position;
      logic                awake_out;
      logic                dir_out;
      logic                step_out;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

endpackage

>>> src/stpax_core.sv
// Axis sequencer: state registers and the per-item next-state logic.
module stpax_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  logic [stpax_pkg::MODE_BITS-1:0]   mode,
   input  logic signed [stpax_pkg::MOVE_BITS-1:0] move_steps,
   input  logic                              home_sensor,
   input  logic [stpax_pkg::POS_BITS-1:0]    max_position,
   input  logic [stpax_pkg::CNT_BITS-1:0]    step_interval,
   output stpax_pkg::rsp_type                result
);

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_HIGH       = 3'd1,
      PH_LOW        = 3'd2,
      PH_WAIT       = 3'd3,
      PH_HOME_CHECK = 3'd4
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [stpax_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic [stpax_pkg::CNT_BITS-1:0]    left_ff, left_in;
   logic [stpax_pkg::CNT_BITS-1:0]    wait_ff, wait_in;
   logic                              dir_ff, dir_in;
   logic                              awake_ff, awake_in;
   logic                              homing_ff, homing_in;

   logic                              level;
   logic                              rej;
   logic                              busy;
   logic signed [stpax_pkg::MOVE_BITS:0] target;
   logic [stpax_pkg::MOVE_BITS-1:0]   neg_steps;
   logic [stpax_pkg::CNT_BITS-1:0]    move_len;
   phase_type                         period_next;

   assign busy      = (phase_ff != PH_IDLE);
   assign target    = $signed({2'b00, pos_ff}) + {move_steps[stpax_pkg::MOVE_BITS-1], move_steps};
   assign neg_steps = stpax_pkg::MOVE_BITS'(-move_steps);
   assign move_len  = move_steps[stpax_pkg::MOVE_BITS-1] ?
                      neg_steps[stpax_pkg::CNT_BITS-1:0] :
                      move_steps[stpax_pkg::CNT_BITS-1:0];

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      left_in     = left_ff;
      wait_in     = wait_ff;
      dir_in      = dir_ff;
      awake_in    = awake_ff;
      homing_in   = homing_ff;
      level       = 1'b0;
      rej         = 1'b0;
      period_next = PH_IDLE;
      case (mode)
         stpax_pkg::MODE_TICK: begin
            case (phase_ff)
               PH_HOME_CHECK: begin
                  if (home_sensor) begin
                     pos_in    = '0;
                     awake_in  = 1'b0;
                     homing_in = 1'b0;
                     phase_in  = PH_IDLE;
                  end else begin
                     level    = 1'b1;
                     phase_in = PH_LOW;
                  end
               end
               PH_HIGH: begin
                  level    = 1'b1;
                  phase_in = PH_LOW;
               end
               PH_LOW: begin
                  // Count the step at the end of the low tick; homing keeps position
                  if (!homing_ff) begin
                     pos_in = dir_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
                     if (left_ff != '0) begin
                        left_in = left_ff - 1'b1;
                     end
                  end
                  if (homing_ff) begin
                     period_next = PH_HOME_CHECK;
                  end else if (left_in == '0) begin
                     period_next = PH_IDLE;
                  end else begin
                     period_next = PH_HIGH;
                  end
                  if (step_interval != '0) begin
                     wait_in  = step_interval;
                     phase_in = PH_WAIT;
                  end else begin
                     phase_in = period_next;
                  end
               end
               PH_WAIT: begin
                  if (wait_ff != '0) begin
                     wait_in = wait_ff - 1'b1;
                  end
                  if (homing_ff) begin
                     period_next = PH_HOME_CHECK;
                  end else if (left_ff == '0) begin
                     period_next = PH_IDLE;
                  end else begin
                     period_next = PH_HIGH;
                  end
                  if (wait_in == '0) begin
                     phase_in = period_next;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         stpax_pkg::MODE_MOVE: begin
            if (busy || target < 0 || target > $signed({2'b00, max_position})) begin
               rej = 1'b1;
            end else begin
               dir_in   = move_steps[stpax_pkg::MOVE_BITS-1];
               left_in  = move_len;
               phase_in = (move_len != '0) ? PH_HIGH : PH_IDLE;
            end
         end
         stpax_pkg::MODE_HOME: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               awake_in  = 1'b1;
               dir_in    = 1'b1;
               homing_in = 1'b1;
               left_in   = '0;
               phase_in  = PH_HOME_CHECK;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.step_out  = level;
      result.dir_out   = dir_in;
      result.awake_out = awake_in;
      result.position  = pos_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         left_ff   <= '0;
         wait_ff   <= '0;
         dir_ff    <= 1'b0;
         awake_ff  <= 1'b0;
         homing_ff <= 1'b0;
      end else if (item_valid) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         left_ff   <= left_in;
         wait_ff   <= wait_in;
         dir_ff    <= dir_in;
         awake_ff  <= awake_in;
         homing_ff <= homing_in;
      end
   end

endmodule

>>> src/stpax_rsp_buf.sv
// Two-entry result register with skid stage for the response stream.
module stpax_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  stpax_pkg::rsp_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output stpax_pkg::rsp_type out_data
);

   logic               main_valid_ff;
   logic               skid_valid_ff;
   stpax_pkg::rsp_type main_data_ff;
   stpax_pkg::rsp_type skid_data_ff;
   logic               push;
   logic               pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            // Promote the parked beat
            main_data_ff  <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            main_data_ff <= in_data;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_data_ff  <= in_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

>>> src/stepper_axis_step_dir_homing_unit.sv
// Top level of the single-axis stepper step/dir generator with homing.
//
//   port group   dir   beat contents
//   req_*        in    tuser: mode; tdata: move_steps, home_sensor
//   rsp_*        out   tdata: step_out .. rejected, one beat per req beat
//   csr_*        in    APB registers: max_position @0x0, step_interval @0x4
//
// One req beat is taken every cycle while req_tready is high; its rsp beat is
// valid on the next cycle unless rsp is stalled. Beyond the result register a
// skid stage holds one more beat; req_tready drops once two rsp beats stall.
// Synchronous active-high reset clears the axis state and both registers
// back to max_position 2000, step_interval 0; no clearing pass.
module stepper_axis_step_dir_homing_unit (
   input  logic                                clock,
   input  logic                                reset,
   // [16:0] move_steps, [17] home_sensor, [23:18] zero
   input  logic [stpax_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] mode
   input  logic [stpax_pkg::MODE_BITS-1:0]     req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] step_out, [1] dir_out, [2] awake_out, [18:3] position,
   // [19] busy_res, [20] rejected, [23:21] zero
   output logic [stpax_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [stpax_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [stpax_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [stpax_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   logic [stpax_pkg::POS_BITS-1:0] max_pos_ff;
   logic [stpax_pkg::CNT_BITS-1:0] interval_ff;
   logic                           csr_wr;
   logic                           req_fire;
   stpax_pkg::rsp_type             core_rsp;
   stpax_pkg::rsp_type             buf_rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == stpax_pkg::REG_STEP_INTERVAL) ?
                       {{(stpax_pkg::CSR_DATA_W-stpax_pkg::CNT_BITS){1'b0}}, interval_ff} :
                       {{(stpax_pkg::CSR_DATA_W-stpax_pkg::POS_BITS){1'b0}}, max_pos_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pos_ff  <= stpax_pkg::MAX_POSITION_RESET;
         interval_ff <= stpax_pkg::STEP_INTERVAL_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == stpax_pkg::REG_MAX_POSITION) begin
            max_pos_ff <= csr_pwdata[stpax_pkg::POS_BITS-1:0];
         end else begin
            interval_ff <= csr_pwdata[stpax_pkg::CNT_BITS-1:0];
         end
      end
   end

   assign req_fire = req_tvalid && req_tready;

   stpax_core u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_fire),
      .mode          (req_tuser),
      .move_steps    ($signed(req_tdata[stpax_pkg::MOVE_BITS-1:0])),
      .home_sensor   (req_tdata[stpax_pkg::MOVE_BITS]),
      .max_position  (max_pos_ff),
      .step_interval (interval_ff),
      .result        (core_rsp)
   );

   stpax_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_rsp)
   );

   assign rsp_tdata = {{(stpax_pkg::RSP_DATA_W-stpax_pkg::RSP_BITS){1'b0}}, buf_rsp};

endmodule

>>> src/stpax_checker.sv
// Port-level assertions for the stepper axis unit, bound to the top level.
module stpax_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [stpax_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted req beat produced no rsp beat");

   // A step pulse leaves the sequence running, and a refused command never pulses
   a_pulse_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[19] && !rsp_tdata[20])
      else $error("step pulse outside a running sequence");

endmodule

bind stepper_axis_step_dir_homing_unit stpax_checker u_stpax_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
